[rtl/ttg_pkg.sv]
// ttg_pkg: widths, state encodings and the control word of the triangle tangent generator
// no dependencies; imported by every module of the block

package ttg_pkg;

	localparam int POS_W     = 32;             // Q16.16 position and tangent
	localparam int UV_W      = 18;             // Q4.14 texture coordinate
	localparam int UVD_W     = UV_W + 1;       // texture coordinate delta
	localparam int EDGE_W    = POS_W + 1;      // position edge
	localparam int PROD_W    = EDGE_W + UVD_W; // shared multiplier product
	localparam int NUM_W     = PROD_W + 1;     // numerator per axis
	localparam int NMAG_W    = PROD_W;         // numerator magnitude
	localparam int DEN_W     = 2 * UVD_W + 1;  // uv determinant
	localparam int DMAG_W    = DEN_W - 1;      // determinant magnitude
	localparam int REM_W     = DMAG_W + 1;     // divider partial remainder
	localparam int TAN_SHIFT = 14;             // uv fraction bits kept in the quotient
	localparam int QUO_W     = POS_W - 1;      // quotient bits below saturation
	localparam int SAT_SHIFT = QUO_W - TAN_SHIFT;
	localparam int CNT_W     = 5;              // divider step counter
	localparam int AXES      = 3;

	localparam logic [1:0] CORNER_FIRST  = 2'd0;
	localparam logic [1:0] CORNER_SECOND = 2'd1;
	localparam logic [1:0] AXIS_LAST     = 2'd2;
	localparam logic [1:0] OIDX_LAST     = 2'd2;

	localparam logic [POS_W-1:0] SAT_MAG = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [UV_W-1:0]   uv_t;
	typedef logic signed [UVD_W-1:0]  uvd_t;
	typedef logic signed [EDGE_W-1:0] edge_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEN_A,
		ST_DEN_B,
		ST_DEN_S,
		ST_DEN_ABS,
		ST_EDGE,
		ST_NUM_A,
		ST_NUM_B,
		ST_NUM_S,
		ST_NUM_ABS,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} ttg_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_PREP,
		DV_ITER,
		DV_ROUND
	} ttg_div_state_t;

	typedef enum logic [1:0] {
		MS_DEN_A,
		MS_DEN_B,
		MS_NUM_A,
		MS_NUM_B
	} mul_sel_t;

	typedef struct packed {
		logic       in_ready;
		logic       store0;
		logic       store1;
		logic       take_third;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic       acc_load;
		logic       den_sub;
		logic       den_abs;
		logic       edge_ld;
		logic       num_sub;
		logic       num_abs;
		logic       div_start;
		logic       tan_ld;
		logic       out_valid;
		logic       last;
		logic [1:0] oidx;
	} ttg_ctrl_t;

endpackage

[rtl/ttg_mul.sv]
// ttg_mul: shared signed multiplier with a registered product
// depends on ttg_pkg

module ttg_mul import ttg_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  edge_t a,
	input  uvd_t  b,
	output prod_t prod
);

	prod_t prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

[rtl/ttg_div.sv]
// ttg_div: iterative restoring divider, one quotient bit per cycle, with rounding
// and saturation of the signed Q16.16 result; depends on ttg_pkg

module ttg_div import ttg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NMAG_W-1:0] nmag,
	input  logic [DMAG_W-1:0] dmag,
	input  logic              neg,
	output logic              done,
	output logic [POS_W-1:0]  quo
);

	ttg_div_state_t state_q, state_d;

	logic [NMAG_W-1:0] n_q;
	logic [DMAG_W-1:0] d_q;
	logic              neg_q;
	logic              sat_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  low_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [DMAG_W+SAT_SHIFT-1:0] n_ext, d_ext;
	logic                        sat;
	logic [REM_W-1:0]            trial;
	logic [REM_W:0]              diff;
	logic                        ge;
	logic                        rnd;
	logic [POS_W-1:0]            mag;

	// overflow when n * 2^14 / d reaches 2^31
	assign n_ext = (DMAG_W+SAT_SHIFT)'(n_q);
	assign d_ext = {d_q, {SAT_SHIFT{1'b0}}};
	assign sat   = n_ext >= d_ext;

	assign trial = {rem_q[REM_W-2:0], low_q[QUO_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, d_q};
	assign ge    = !diff[REM_W];

	// round half away from zero on the magnitude
	assign rnd = {rem_q, 1'b0} >= {2'b00, d_q};
	assign mag = sat_q ? SAT_MAG : {1'b0, low_q} + POS_W'(rnd);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE:  if (start) state_d = DV_PREP;
			DV_PREP:  state_d = sat ? DV_ROUND : DV_ITER;
			DV_ITER:  if (cnt_q == '0) state_d = DV_ROUND;
			DV_ROUND: state_d = DV_IDLE;
			default:  state_d = DV_IDLE;
		endcase
	end

	always_comb begin
		done = 1'b0;
		quo  = '0;
		unique case (state_q)
			DV_ROUND: begin
				done = 1'b1;
				if (neg_q) begin
					quo = -mag;
				end else begin
					quo = mag[POS_W-1] ? POS_MAX : mag;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DV_IDLE: begin
				if (start) begin
					n_q   <= nmag;
					d_q   <= dmag;
					neg_q <= neg;
				end
			end
			DV_PREP: begin
				sat_q <= sat;
				rem_q <= REM_W'(n_q[NMAG_W-1:SAT_SHIFT]);
				low_q <= {n_q[SAT_SHIFT-1:0], {TAN_SHIFT{1'b0}}};
				cnt_q <= CNT_W'(QUO_W - 1);
			end
			DV_ITER: begin
				rem_q <= ge ? diff[REM_W-1:0] : trial;
				low_q <= {low_q[QUO_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == DV_IDLE)
		else $error("divider started while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DV_ITER |-> rem_q < REM_W'(d_q))
		else $error("partial remainder not below divisor");

	a_round_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DV_ROUND |=> state_q == DV_IDLE)
		else $error("divider result held for more than one cycle");

endmodule

[rtl/ttg_ctrl.sv]
// ttg_ctrl: sequencer of the tangent generator; corner count, axis and output index
// depends on ttg_pkg

module ttg_ctrl import ttg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	input  logic      degen,
	input  logic      div_done,
	output ttg_ctrl_t ctrl
);

	ttg_state_t state_q, state_d;
	logic [1:0] cnt_q;
	logic [1:0] axis_q;
	logic [1:0] oidx_q;
	logic       in_acc;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid && cnt_q[1]) state_d = ST_DEN_A;
			ST_DEN_A:    state_d = ST_DEN_B;
			ST_DEN_B:    state_d = ST_DEN_S;
			ST_DEN_S:    state_d = ST_DEN_ABS;
			ST_DEN_ABS:  state_d = degen ? ST_OUT : ST_EDGE;
			ST_EDGE:     state_d = ST_NUM_A;
			ST_NUM_A:    state_d = ST_NUM_B;
			ST_NUM_B:    state_d = ST_NUM_S;
			ST_NUM_S:    state_d = ST_NUM_ABS;
			ST_NUM_ABS:  state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) state_d = (axis_q == AXIS_LAST) ? ST_OUT : ST_EDGE;
			end
			ST_OUT:      if (out_ready && oidx_q == OIDX_LAST) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl      = '0;
		ctrl.oidx = oidx_q;
		ctrl.last = oidx_q == OIDX_LAST;
		unique case (state_q)
			ST_IDLE:     ctrl.in_ready = 1'b1;
			ST_DEN_A: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_DEN_A;
			end
			ST_DEN_B: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_sel  = MS_DEN_B;
				ctrl.acc_load = 1'b1;
			end
			ST_DEN_S:    ctrl.den_sub = 1'b1;
			ST_DEN_ABS:  ctrl.den_abs = 1'b1;
			ST_EDGE:     ctrl.edge_ld = 1'b1;
			ST_NUM_A: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_NUM_A;
			end
			ST_NUM_B: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_sel  = MS_NUM_B;
				ctrl.acc_load = 1'b1;
			end
			ST_NUM_S:    ctrl.num_sub = 1'b1;
			ST_NUM_ABS:  ctrl.num_abs = 1'b1;
			ST_DIV_GO:   ctrl.div_start = 1'b1;
			ST_DIV_WAIT: ctrl.tan_ld = div_done;
			ST_OUT: begin
				// first two corners of the next triangle may come in while results drain
				ctrl.out_valid = 1'b1;
				ctrl.in_ready  = !cnt_q[1];
			end
			default: ;
		endcase
		in_acc          = in_valid && ctrl.in_ready;
		ctrl.store0     = in_acc && cnt_q == CORNER_FIRST;
		ctrl.store1     = in_acc && cnt_q == CORNER_SECOND;
		ctrl.take_third = in_acc && cnt_q[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			axis_q  <= '0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cnt_q <= cnt_q[1] ? 2'd0 : cnt_q + 2'd1;
			end
			if (ctrl.den_abs) begin
				axis_q <= '0;
			end else if (ctrl.tan_ld) begin
				axis_q <= axis_q + 2'd1;
			end
			if (ctrl.out_valid && out_ready) begin
				oidx_q <= (oidx_q == OIDX_LAST) ? 2'd0 : oidx_q + 2'd1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("corner count out of range");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV_WAIT)
		else $error("divider finished outside the wait state");

	a_third_starts: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take_third |=> state_q == ST_DEN_A)
		else $error("third corner did not start the determinant");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_ready && oidx_q == OIDX_LAST) |=> state_q == ST_IDLE)
		else $error("results continued past the last corner");

endmodule

[rtl/triangle_tangent_generator_core.sv]
// triangle_tangent_generator_core: per-triangle tangent from positions and uv
// first and second corners are only stored; the third starts the determinant work, then
// per axis 5 multiply/subtract steps and the one-bit-per-cycle divider; a zero determinant
// skips the axes and gives zero tangents flagged degenerate; results go out as three words,
// one per corner; the next triangle's first two corners may be stored while they drain
// arst_n clears the sequencer, corner count and handshakes; held corners need no reset

module triangle_tangent_generator_core import ttg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pos_t             pos_x,
	input  pos_t             pos_y,
	input  pos_t             pos_z,
	input  uv_t              tex_u,
	input  uv_t              tex_v,
	output logic             out_valid,
	input  logic             out_ready,
	output pos_t             tangent_x,
	output pos_t             tangent_y,
	output pos_t             tangent_z,
	output logic             degenerate,
	output logic [1:0]       corner_index,
	output logic             last_of_run
);

	ttg_ctrl_t ctrl;

	pos_t held0_q [AXES];
	pos_t held1_q [AXES];
	pos_t p2_q    [AXES];
	uv_t  u0_q, v0_q, u1_q, v1_q;
	uvd_t du1_q, dv1_q, du2_q, dv2_q;

	edge_t             e1_q, e2_q;
	prod_t             acc_q;
	logic [DEN_W-1:0]  den_q;
	logic              den_sign_q;
	logic [DMAG_W-1:0] dmag_q;
	logic [NUM_W-1:0]  num_q;
	logic [NMAG_W-1:0] nmag_q;
	logic              neg_q;
	pos_t              tan_q [AXES];
	logic              degen_q;

	edge_t             mul_a;
	uvd_t              mul_b;
	prod_t             prod;
	prod_t             den_diff;
	logic [DEN_W-1:0]  den_negv;
	logic [NUM_W-1:0]  num_negv;
	logic              degen;
	logic              div_done;
	logic [POS_W-1:0]  quo;

	ttg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.degen     (degen),
		.div_done  (div_done),
		.ctrl      (ctrl)
	);

	always_comb begin
		unique case (ctrl.mul_sel)
			MS_DEN_A: begin
				mul_a = {{(EDGE_W-UVD_W){du1_q[UVD_W-1]}}, du1_q};
				mul_b = dv2_q;
			end
			MS_DEN_B: begin
				mul_a = {{(EDGE_W-UVD_W){dv1_q[UVD_W-1]}}, dv1_q};
				mul_b = du2_q;
			end
			MS_NUM_A: begin
				mul_a = e1_q;
				mul_b = dv2_q;
			end
			MS_NUM_B: begin
				mul_a = e2_q;
				mul_b = dv1_q;
			end
			default: begin
				mul_a = e1_q;
				mul_b = dv2_q;
			end
		endcase
	end

	ttg_mul u_mul (
		.clk  (clk),
		.en   (ctrl.mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	ttg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.div_start),
		.nmag   (nmag_q),
		.dmag   (dmag_q),
		.neg    (neg_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign den_diff = acc_q - prod;
	assign den_negv = -den_q;
	assign num_negv = -num_q;
	assign degen    = den_q == '0;

	always_ff @(posedge clk) begin
		if (ctrl.store0) begin
			held0_q[0] <= pos_x;
			held0_q[1] <= pos_y;
			held0_q[2] <= pos_z;
			u0_q       <= tex_u;
			v0_q       <= tex_v;
		end
		if (ctrl.store1) begin
			held1_q[0] <= pos_x;
			held1_q[1] <= pos_y;
			held1_q[2] <= pos_z;
			u1_q       <= tex_u;
			v1_q       <= tex_v;
		end
		if (ctrl.take_third) begin
			p2_q[0] <= pos_x;
			p2_q[1] <= pos_y;
			p2_q[2] <= pos_z;
			du1_q   <= {u1_q[UV_W-1], u1_q} - {u0_q[UV_W-1], u0_q};
			dv1_q   <= {v1_q[UV_W-1], v1_q} - {v0_q[UV_W-1], v0_q};
			du2_q   <= {tex_u[UV_W-1], tex_u} - {u0_q[UV_W-1], u0_q};
			dv2_q   <= {tex_v[UV_W-1], tex_v} - {v0_q[UV_W-1], v0_q};
		end
		// edges of the current axis always sit at index 0; rotate after use
		if (ctrl.edge_ld) begin
			e1_q <= {held1_q[0][POS_W-1], held1_q[0]} - {held0_q[0][POS_W-1], held0_q[0]};
			e2_q <= {p2_q[0][POS_W-1], p2_q[0]} - {held0_q[0][POS_W-1], held0_q[0]};
			for (int k = 0; k < AXES - 1; k++) begin
				held0_q[k] <= held0_q[k+1];
				held1_q[k] <= held1_q[k+1];
				p2_q[k]    <= p2_q[k+1];
			end
			held0_q[AXES-1] <= held0_q[0];
			held1_q[AXES-1] <= held1_q[0];
			p2_q[AXES-1]    <= p2_q[0];
		end
		if (ctrl.acc_load) begin
			acc_q <= prod;
		end
		if (ctrl.den_sub) begin
			den_q <= den_diff[DEN_W-1:0];
		end
		if (ctrl.den_abs) begin
			den_sign_q <= den_q[DEN_W-1];
			dmag_q     <= den_q[DEN_W-1] ? den_negv[DMAG_W-1:0] : den_q[DMAG_W-1:0];
			degen_q    <= degen;
			if (degen) begin
				for (int k = 0; k < AXES; k++) begin
					tan_q[k] <= '0;
				end
			end
		end
		if (ctrl.num_sub) begin
			num_q <= {acc_q[PROD_W-1], acc_q} - {prod[PROD_W-1], prod};
		end
		if (ctrl.num_abs) begin
			nmag_q <= num_q[NUM_W-1] ? num_negv[NMAG_W-1:0] : num_q[NMAG_W-1:0];
			neg_q  <= num_q[NUM_W-1] ^ den_sign_q;
		end
		// axes finish in x, y, z order and shift down
		if (ctrl.tan_ld) begin
			for (int k = 0; k < AXES - 1; k++) begin
				tan_q[k] <= tan_q[k+1];
			end
			tan_q[AXES-1] <= quo;
		end
	end

	assign in_ready     = ctrl.in_ready;
	assign out_valid    = ctrl.out_valid;
	assign tangent_x    = tan_q[0];
	assign tangent_y    = tan_q[1];
	assign tangent_z    = tan_q[2];
	assign degenerate   = degen_q;
	assign corner_index = ctrl.oidx;
	assign last_of_run  = ctrl.last;

endmodule
